// ===== src/cpr_pkg.sv =====
// ----------------------------------------------------------------------------
// cpr_pkg
// shared sizes for the clock page replacement cache and its checker
// ----------------------------------------------------------------------------
package cpr_pkg;

  // built capacity and page number width
  localparam int MAX_ENTRIES = 128;
  localparam int PAGE_BITS   = 20;

  // entry index and entry count widths
  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

  // configuration register
  localparam int CFG_W         = 8;
  localparam int CFG_RESET_VAL = 16;

  // width used for size and fill comparisons
  localparam int SZ_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  // running hit count
  localparam int HIT_W = 32;

endpackage

// ===== src/clock_page_replacement.sv =====
// ----------------------------------------------------------------------------
// clock_page_replacement
// fully associative page cache with clock (second chance) replacement
// ----------------------------------------------------------------------------
// throughput: one item at a time, the next taken once the result is loaded
//   into the output register; the tag scan reads one entry and the sweep
//   clears one bit a cycle
// reset: synchronous, active low; reference bits, hand, fill and hit counts clear
//   at once, tag memory is left as is (entries read only once filled)
// ----------------------------------------------------------------------------
module clock_page_replacement (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration write (cache_size)
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [cpr_pkg::CFG_W-1:0]      cfg_cache_size,
  // page item in
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [cpr_pkg::PAGE_BITS-1:0]  in_page,
  // result item out
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_hit,
  output logic [cpr_pkg::IDX_W-1:0]      out_slot,
  output logic                           out_evicted_valid,
  output logic [cpr_pkg::PAGE_BITS-1:0]  out_evicted_page,
  output logic [cpr_pkg::HIT_W-1:0]      out_hit_total
);

  localparam int IDX_W = cpr_pkg::IDX_W;
  localparam int SZ_W  = cpr_pkg::SZ_W;
  localparam int PG_W  = cpr_pkg::PAGE_BITS;
  localparam int HIT_W = cpr_pkg::HIT_W;
  localparam int MAXE  = cpr_pkg::MAX_ENTRIES;

  // one-hot sequencer states
  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,  // waiting for an item
    ST_SCAN  = 5'b00010,  // pipelined tag search, one entry per cycle
    ST_SWEEP = 5'b00100,  // clock hand clearing reference bits
    ST_EREAD = 5'b01000,  // victim tag arriving from memory
    ST_DONE  = 5'b10000   // result ready, waiting for the output register
  } state_t;

  // tag memory, one read and one write port, registered read data
  logic [PG_W-1:0]   tags_mem [MAXE];
  logic [PG_W-1:0]   rd_data_r;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  logic [IDX_W-1:0]  mem_raddr;

  state_t            state_r, state_nxt;
  logic [SZ_W-1:0]   cfg_r;
  logic [PG_W-1:0]   page_r, page_nxt;
  logic [SZ_W-1:0]   iss_r, iss_nxt;        // next entry to read in the scan
  logic              cmp_vld_r, cmp_vld_nxt; // read data is due for compare
  logic [IDX_W-1:0]  cmp_idx_r, cmp_idx_nxt;
  logic [SZ_W-1:0]   filled_r, filled_nxt;
  logic [IDX_W-1:0]  hand_r, hand_nxt;
  logic [HIT_W-1:0]  hits_r, hits_nxt;
  logic [MAXE-1:0]   ref_r, ref_nxt;

  // result held until the output register is free
  logic              res_hit_r, res_hit_nxt;
  logic [IDX_W-1:0]  res_slot_r, res_slot_nxt;
  logic              res_ev_r, res_ev_nxt;
  logic [PG_W-1:0]   res_ev_page_r, res_ev_page_nxt;

  logic              out_valid_r;
  logic              out_hit_r;
  logic [IDX_W-1:0]  out_slot_r;
  logic              out_ev_r;
  logic [PG_W-1:0]   out_ev_page_r;
  logic [HIT_W-1:0]  out_hits_r;
  logic              out_load;

  // live size: zero counts as one, clipped to the built capacity
  logic [SZ_W-1:0]   live_size;
  logic [SZ_W-1:0]   valid_cnt;
  logic [IDX_W-1:0]  hand_h;
  logic [IDX_W-1:0]  hand_inc;

  assign live_size = (cfg_r == '0) ? SZ_W'(1) :
                     (cfg_r > SZ_W'(MAXE)) ? SZ_W'(MAXE) : cfg_r;
  assign valid_cnt = (filled_r < live_size) ? filled_r : live_size;

  // a hand left beyond a shrunk size restarts at entry zero
  assign hand_h   = (SZ_W'(hand_r) >= live_size) ? '0 : hand_r;
  assign hand_inc = ((SZ_W'(hand_h) + SZ_W'(1)) == live_size) ? '0 :
                    hand_h + IDX_W'(1);

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_load  = (state_r == ST_DONE) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt       = state_r;
    page_nxt        = page_r;
    iss_nxt         = iss_r;
    cmp_vld_nxt     = 1'b0;
    cmp_idx_nxt     = cmp_idx_r;
    filled_nxt      = filled_r;
    hand_nxt        = hand_r;
    hits_nxt        = hits_r;
    ref_nxt         = ref_r;
    res_hit_nxt     = res_hit_r;
    res_slot_nxt    = res_slot_r;
    res_ev_nxt      = res_ev_r;
    res_ev_page_nxt = res_ev_page_r;
    mem_we          = 1'b0;
    mem_waddr       = '0;
    mem_raddr       = iss_r[IDX_W-1:0];

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          page_nxt  = in_page;
          iss_nxt   = '0;
          state_nxt = ST_SCAN;
        end
      end

      ST_SCAN: begin
        if (cmp_vld_r && (rd_data_r == page_r)) begin
          // first matching entry in index order
          res_hit_nxt     = 1'b1;
          res_slot_nxt    = cmp_idx_r;
          res_ev_nxt      = 1'b0;
          res_ev_page_nxt = '0;
          ref_nxt[cmp_idx_r] = 1'b1;
          if (hits_r != '1) begin
            hits_nxt = hits_r + HIT_W'(1);
          end
          state_nxt = ST_DONE;
        end else if (iss_r >= valid_cnt) begin
          // every filled entry compared without a match
          res_hit_nxt     = 1'b0;
          res_ev_page_nxt = '0;
          if (filled_r < live_size) begin
            // free entry left: fill it in order
            mem_we     = 1'b1;
            mem_waddr  = filled_r[IDX_W-1:0];
            ref_nxt[filled_r[IDX_W-1:0]] = 1'b1;
            res_slot_nxt = filled_r[IDX_W-1:0];
            res_ev_nxt   = 1'b0;
            filled_nxt   = filled_r + SZ_W'(1);
            state_nxt    = ST_DONE;
          end else begin
            state_nxt = ST_SWEEP;
          end
        end else begin
          // read the next entry, compare it in the following cycle
          cmp_vld_nxt = 1'b1;
          cmp_idx_nxt = iss_r[IDX_W-1:0];
          iss_nxt     = iss_r + SZ_W'(1);
        end
      end

      ST_SWEEP: begin
        if (ref_r[hand_h]) begin
          // second chance: clear and move on
          ref_nxt[hand_h] = 1'b0;
          hand_nxt        = hand_inc;
        end else begin
          // victim found, fetch its tag
          hand_nxt  = hand_h;
          mem_raddr = hand_h;
          state_nxt = ST_EREAD;
        end
      end

      ST_EREAD: begin
        mem_we          = 1'b1;
        mem_waddr       = hand_r;
        ref_nxt[hand_r] = 1'b1;
        res_slot_nxt    = hand_r;
        res_ev_nxt      = 1'b1;
        res_ev_page_nxt = rd_data_r;
        state_nxt       = ST_DONE;
      end

      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // tag memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      tags_mem[mem_waddr] <= page_r;
    end
    rd_data_r <= tags_mem[mem_raddr];
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cfg_r       <= SZ_W'(cpr_pkg::CFG_RESET_VAL);
      cmp_vld_r   <= 1'b0;
      filled_r    <= '0;
      hand_r      <= '0;
      hits_r      <= '0;
      ref_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cmp_vld_r <= cmp_vld_nxt;
      filled_r  <= filled_nxt;
      hand_r    <= hand_nxt;
      hits_r    <= hits_nxt;
      ref_r     <= ref_nxt;
      if (cfg_valid) begin
        cfg_r <= SZ_W'(cfg_cache_size);
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    page_r        <= page_nxt;
    iss_r         <= iss_nxt;
    cmp_idx_r     <= cmp_idx_nxt;
    res_hit_r     <= res_hit_nxt;
    res_slot_r    <= res_slot_nxt;
    res_ev_r      <= res_ev_nxt;
    res_ev_page_r <= res_ev_page_nxt;
    if (out_load) begin
      out_hit_r     <= res_hit_r;
      out_slot_r    <= res_slot_r;
      out_ev_r      <= res_ev_r;
      out_ev_page_r <= res_ev_page_r;
      out_hits_r    <= hits_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_hit           = out_hit_r;
  assign out_slot          = out_slot_r;
  assign out_evicted_valid = out_ev_r;
  assign out_evicted_page  = out_ev_page_r;
  assign out_hit_total     = out_hits_r;

endmodule

// ===== src/cpr_checker.sv =====
// ----------------------------------------------------------------------------
// cpr_checker
// port-level checks for the clock page replacement cache
// ----------------------------------------------------------------------------
module cpr_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic                           out_hit,
  input  logic [cpr_pkg::IDX_W-1:0]      out_slot,
  input  logic                           out_evicted_valid,
  input  logic [cpr_pkg::PAGE_BITS-1:0]  out_evicted_page,
  input  logic [cpr_pkg::HIT_W-1:0]      out_hit_total
);

  // a stalled result item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_slot) && $stable(out_hit_total))
    else $error("stalled result item changed");

  // a hit never evicts
  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit |-> !out_evicted_valid)
    else $error("hit reported an eviction");

  // no eviction means a zero evicted page
  a_no_evict_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_evicted_valid |-> out_evicted_page == '0)
    else $error("evicted page set without eviction");

  // a hit is counted
  a_hit_counted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit |-> out_hit_total != '0)
    else $error("hit with zero hit total");

  // one item at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while busy");

endmodule

bind clock_page_replacement cpr_checker u_cpr_checker (.*);

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the clock page replacement cache: a scoreboard
// class tracks tags, reference bits, hand and fill count, predicts each
// result and checks it against what comes out of the block
// ----------------------------------------------------------------------------
module tb_top;

  localparam int PAGE_BITS     = cpr_pkg::PAGE_BITS;
  localparam int IDX_W         = cpr_pkg::IDX_W;
  localparam int HIT_W         = cpr_pkg::HIT_W;
  localparam int MAX_ENTRIES   = cpr_pkg::MAX_ENTRIES;
  localparam int CFG_W         = cpr_pkg::CFG_W;
  localparam int CFG_RESET_VAL = cpr_pkg::CFG_RESET_VAL;

  // one result item, with the page that caused it kept for messages
  typedef struct {
    logic [PAGE_BITS-1:0] page;
    logic                 hit;
    logic [IDX_W-1:0]     slot;
    logic                 evicted_valid;
    logic [PAGE_BITS-1:0] evicted_page;
    logic [HIT_W-1:0]     hit_total;
  } cache_result_t;

  // --------------------------------------------------------------------------
  // scoreboard: own copy of the cache state, queue of predicted results
  // --------------------------------------------------------------------------
  class page_cache_scoreboard;
    bit [PAGE_BITS-1:0] tags [MAX_ENTRIES];
    bit                 ref_bits [MAX_ENTRIES];
    int unsigned        hand;
    int unsigned        filled;
    bit [HIT_W-1:0]     hits;
    bit [CFG_W-1:0]     size_reg = CFG_RESET_VAL;
    cache_result_t      predicted_q[$];
    int unsigned        errors;

    // size 0 behaves as 1, anything above capacity as the capacity
    static function int unsigned live_entries_for(bit [CFG_W-1:0] v);
      if (v == 0) return 1;
      if (v > MAX_ENTRIES) return MAX_ENTRIES;
      return 32'(v);
    endfunction

    function void write_size(bit [CFG_W-1:0] v);
      size_reg = v;
    endfunction

    // work out the result of one accepted page and queue it
    function void note_page(bit [PAGE_BITS-1:0] pg);
      cache_result_t exp;
      int unsigned   es;
      int unsigned   searched;
      int unsigned   steps;
      es       = live_entries_for(size_reg);
      searched = (filled < es) ? filled : es;
      exp      = '{page: pg, hit: 1'b0, slot: '0, evicted_valid: 1'b0,
                   evicted_page: '0, hit_total: '0};
      // lowest matching index wins, duplicates left by a resize included
      for (int i = 0; i < searched; i++) begin
        if (!exp.hit && tags[i] == pg) begin
          exp.hit  = 1'b1;
          exp.slot = IDX_W'(i);
        end
      end
      if (exp.hit) begin
        ref_bits[exp.slot] = 1'b1;
        if (hits != '1) hits++;
      end else if (filled < es) begin
        exp.slot       = IDX_W'(filled);
        tags[filled]     = pg;
        ref_bits[filled] = 1'b1;
        filled++;
      end else begin
        if (hand >= es) hand = 0;
        // second chance sweep, one lap clears every bit
        for (steps = 0; steps < 2 * es && ref_bits[hand]; steps++) begin
          ref_bits[hand] = 1'b0;
          hand = (hand + 1) % es;
        end
        exp.slot          = IDX_W'(hand);
        exp.evicted_valid = 1'b1;
        exp.evicted_page  = tags[hand];
        tags[hand]        = pg;
        ref_bits[hand]    = 1'b1;
      end
      exp.hit_total = hits;
      predicted_q.push_back(exp);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 40) $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task check_result(cache_result_t got);
      cache_result_t exp;
      if (predicted_q.size() == 0) begin
        report($sformatf("result item with nothing pending (slot %0d)", got.slot));
        return;
      end
      exp = predicted_q.pop_front();
      if (got.hit !== exp.hit)
        report($sformatf("page %05h hit %b, predicted %b", exp.page, got.hit, exp.hit));
      if (got.slot !== exp.slot)
        report($sformatf("page %05h slot %0d, predicted %0d", exp.page, got.slot,
                         exp.slot));
      if (got.evicted_valid !== exp.evicted_valid)
        report($sformatf("page %05h evicted_valid %b, predicted %b", exp.page,
                         got.evicted_valid, exp.evicted_valid));
      if (got.evicted_page !== exp.evicted_page)
        report($sformatf("page %05h evicted_page %05h, predicted %05h", exp.page,
                         got.evicted_page, exp.evicted_page));
      if (got.hit_total !== exp.hit_total)
        report($sformatf("page %05h hit_total %0d, predicted %0d", exp.page,
                         got.hit_total, exp.hit_total));
    endtask
  endclass

  // --------------------------------------------------------------------------
  // signals and the block
  // --------------------------------------------------------------------------
  logic                 clk;
  logic                 rst_n          = 1'b0;
  logic                 cfg_valid      = 1'b0;
  logic                 cfg_ready;
  logic [CFG_W-1:0]     cfg_cache_size = '0;
  logic                 in_valid       = 1'b0;
  logic                 in_ready;
  logic [PAGE_BITS-1:0] in_page        = '0;
  logic                 out_valid;
  logic                 out_ready      = 1'b0;
  logic                 out_hit;
  logic [IDX_W-1:0]     out_slot;
  logic                 out_evicted_valid;
  logic [PAGE_BITS-1:0] out_evicted_page;
  logic [HIT_W-1:0]     out_hit_total;

  clock_page_replacement DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_cache_size    (cfg_cache_size),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_page           (in_page),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_hit           (out_hit),
    .out_slot          (out_slot),
    .out_evicted_valid (out_evicted_valid),
    .out_evicted_page  (out_evicted_page),
    .out_hit_total     (out_hit_total)
  );

  page_cache_scoreboard sb = new;

  // bench state shared by the driving processes
  int unsigned burst_left;   // items left in the current sender burst
  bit          squeeze_req;  // asks the receiver for one long hold-off

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // monitors: every handshake is sampled at the edge that completes it
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && cfg_valid && cfg_ready) sb.write_size(cfg_cache_size);
    if (rst_n && in_valid && in_ready) sb.note_page(in_page);
  end

  always @(posedge clk) begin
    cache_result_t seen;
    if (rst_n && out_valid && out_ready) begin
      seen.page          = '0;
      seen.hit           = out_hit;
      seen.slot          = out_slot;
      seen.evicted_valid = out_evicted_valid;
      seen.evicted_page  = out_evicted_page;
      seen.hit_total     = out_hit_total;
      sb.check_result(seen);
    end
  end

  // --------------------------------------------------------------------------
  // receiver: segments of differing stall density, plus one long hold-off
  // --------------------------------------------------------------------------
  initial begin
    int unsigned mode;
    int unsigned seg_len;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (squeeze_req) begin
        // long hold-off so the cache backs up and stops taking items
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
        squeeze_req = 1'b0;
      end else begin
        mode    = $urandom_range(0, 3);
        seg_len = $urandom_range(20, 200);
        repeat (seg_len) begin
          case (mode)
            0: begin
              out_ready <= 1'b1;
            end
            1: begin
              out_ready <= 1'($urandom_range(0, 1));
            end
            2: begin
              out_ready <= ($urandom_range(0, 7) != 0);
            end
            default: begin
              out_ready <= ($urandom_range(0, 3) == 0);
            end
          endcase
          @(posedge clk);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // sender side
  // --------------------------------------------------------------------------

  // offer one page, starting a new burst (maybe after a gap) when the old
  // one has run out; valid stays high across items inside a burst
  task automatic offer_page(input logic [PAGE_BITS-1:0] pg);
    int unsigned gap;
    if (burst_left == 0) begin
      if (squeeze_req || $urandom_range(0, 3) == 0) gap = 0;
      else gap = $urandom_range(1, 10);
      burst_left = $urandom_range(1, 16);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_page  <= pg;
    do @(posedge clk); while (!in_ready);
    burst_left--;
  endtask

  // write cache_size once every pending result is back
  task automatic set_cache_size(input logic [CFG_W-1:0] v);
    in_valid   <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (sb.predicted_q.size() != 0);
    repeat (2) @(posedge clk);
    cfg_valid      <= 1'b1;
    cfg_cache_size <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  int                   fixed_sizes [] = '{1, 2, 3, 8, 4, 16, 128, 5, 0, 7, 255, 3,
                                           12, 1, 6, 24};
  logic [PAGE_BITS-1:0] pool [];
  logic [PAGE_BITS-1:0] last_page;
  int unsigned          random_sent;
  int unsigned          phase;
  int unsigned          size_val;
  int unsigned          es;
  int unsigned          n_items;
  int unsigned          pick;
  int unsigned          drain_wait;

  initial begin
    burst_left  = 0;
    squeeze_req = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset size of 16: fills, hits, all-zero and all-one pages
    offer_page(20'h00000);
    offer_page(20'hFFFFF);
    offer_page(20'h00000);
    offer_page(20'hFFFFF);
    offer_page(20'h5A5A5);
    offer_page(20'hA5A5A);

    // shrink below the fill count: only the first two entries take part,
    // full at once, so misses sweep and evict
    set_cache_size(8'd2);
    offer_page(20'h00000);
    offer_page(20'hA5A5A);
    offer_page(20'hFFFFF);
    offer_page(20'h12345);

    // size zero behaves as a single entry
    set_cache_size(8'd0);
    offer_page(20'h12345);
    offer_page(20'h54321);
    offer_page(20'h54321);

    // oversize clamps to capacity, the unfilled entries fill in order
    set_cache_size(8'd255);
    offer_page(20'h00001);
    offer_page(20'h80000);
    offer_page(20'h12345);
    offer_page(20'h5A5A5);

    // the saturating hit count needs four billion hits, out of reach here;
    // the predictor still holds the count at its top value

    // random phases: fixed sizes first, then mostly small ones
    random_sent = 0;
    phase       = 0;
    last_page   = '0;
    while (random_sent < 1850) begin
      if (phase < fixed_sizes.size()) begin
        size_val = fixed_sizes[phase];
      end else begin
        pick = $urandom_range(0, 19);
        if (pick == 0) size_val = 0;
        else if (pick == 1) size_val = $urandom_range(21, 40);
        else size_val = $urandom_range(1, 20);
      end
      set_cache_size(CFG_W'(size_val));
      es      = page_cache_scoreboard::live_entries_for(CFG_W'(size_val));
      n_items = (es >= 64) ? 160 : $urandom_range(40, 110);

      // a working set a bit larger than the cache gives hits and evictions
      pool = new[es + $urandom_range(0, es / 2 + 2)];
      foreach (pool[k]) pool[k] = PAGE_BITS'($urandom_range(0, (1 << PAGE_BITS) - 1));

      if (phase == 4) squeeze_req = 1'b1;

      repeat (n_items) begin
        pick = $urandom_range(0, 99);
        if (pick < 10) last_page = PAGE_BITS'($urandom_range(0, (1 << PAGE_BITS) - 1));
        else if (pick >= 20) last_page = pool[$urandom_range(0, pool.size() - 1)];
        offer_page(last_page);
        random_sent++;
      end
      phase++;
    end

    // drain, then give stray results a chance to show up
    in_valid   <= 1'b0;
    drain_wait = 0;
    while (sb.predicted_q.size() != 0 && drain_wait < 200000) begin
      @(posedge clk);
      drain_wait++;
    end
    repeat (300) @(posedge clk);
    if (sb.predicted_q.size() != 0)
      sb.report($sformatf("%0d predicted results never arrived", sb.predicted_q.size()));

    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // hard stop if the block hangs
  initial begin
    #20000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
